// File: hw/rtl/rect_sprite_quad_clipper_core_assert.svh
// assertion helpers for the checker file
`ifndef RECT_SPRITE_QUAD_CLIPPER_CORE_ASSERT_SVH
`define RECT_SPRITE_QUAD_CLIPPER_CORE_ASSERT_SVH

// checked outside reset
`define RSQC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RSQC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rsqc_pkg.sv
package rsqc_pkg;

	localparam int CW = 24;
	localparam int SPS = 2;
	localparam int DIV_STAGES = (CW + SPS - 1) / SPS;
	localparam int LW = DIV_STAGES * SPS;
	localparam int PW = 2 * CW + 1;
	localparam int HW = PW - LW;
	localparam int SW = LW + 3;
	localparam int DEPTH = DIV_STAGES + 4;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_ENABLE = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_LEFT   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_TOP    = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_RIGHT  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_BOTTOM = IDX_W'(4);

	localparam logic [1:0] ACT_BAR    = 2'd0;
	localparam logic [1:0] ACT_QUAD   = 2'd1;
	localparam logic [1:0] ACT_SPRITE = 2'd2;
	localparam logic [1:0] ACT_PASS   = 2'd3;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW-1:0] mag_t;
	typedef logic [CW:0] ext_t;
	typedef logic [PW-1:0] prod_t;
	typedef logic [LW-1:0] quo_t;

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

	// edges ordered left, top, right, bottom
	typedef struct packed {
		logic en;
		coord_t [3:0] bound;
	} cfg_t;

	typedef struct packed {
		logic neg;
		ext_t mag;
		mag_t mv;
		mag_t dv;
		coord_t src;
	} lane_t;

	typedef struct packed {
		coord_t [3:0] dst;
		lane_t [3:0] lane;
	} front_t;

	typedef struct packed {
		logic neg;
		prod_t prod;
		mag_t dv;
		coord_t src;
	} mul_lane_t;

	typedef struct packed {
		coord_t [3:0] dst;
		mul_lane_t [3:0] lane;
	} mul_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		mag_t rem;
		quo_t lo;
		mag_t dv;
		coord_t src;
	} div_lane_t;

	typedef struct packed {
		coord_t [3:0] dst;
		div_lane_t [3:0] lane;
	} pipe_t;

	typedef struct packed {
		coord_t [3:0] dst;
		coord_t [3:0] src;
	} result_t;

endpackage

// File: hw/rtl/rsqc_if.sv
interface rsqc_req_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic flip_x;
	logic flip_y;
	rsqc_pkg::coord_t dst_left;
	rsqc_pkg::coord_t dst_top;
	rsqc_pkg::coord_t dst_right;
	rsqc_pkg::coord_t dst_bottom;
	rsqc_pkg::coord_t src_left;
	rsqc_pkg::coord_t src_top;
	rsqc_pkg::coord_t src_right;
	rsqc_pkg::coord_t src_bottom;

	modport source(output valid, action, flip_x, flip_y, dst_left, dst_top, dst_right,
		dst_bottom, src_left, src_top, src_right, src_bottom, input ready);
	modport sink(input valid, action, flip_x, flip_y, dst_left, dst_top, dst_right,
		dst_bottom, src_left, src_top, src_right, src_bottom, output ready);
endinterface

interface rsqc_rsp_if;
	logic valid;
	logic ready;
	rsqc_pkg::coord_t out_dst_left;
	rsqc_pkg::coord_t out_dst_top;
	rsqc_pkg::coord_t out_dst_right;
	rsqc_pkg::coord_t out_dst_bottom;
	rsqc_pkg::coord_t out_src_left;
	rsqc_pkg::coord_t out_src_top;
	rsqc_pkg::coord_t out_src_right;
	rsqc_pkg::coord_t out_src_bottom;

	modport source(output valid, out_dst_left, out_dst_top, out_dst_right, out_dst_bottom,
		out_src_left, out_src_top, out_src_right, out_src_bottom, input ready);
	modport sink(input valid, out_dst_left, out_dst_top, out_dst_right, out_dst_bottom,
		out_src_left, out_src_top, out_src_right, out_src_bottom, output ready);
endinterface

// File: hw/rtl/rsqc_front.sv
module rsqc_front (
	input  logic clk,
	input  logic arst_n,
	input  rsqc_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] action,
	input  logic [1:0] flip,
	input  rsqc_pkg::coord_t [3:0] dst_i,
	input  rsqc_pkg::coord_t [3:0] src_i,
	output logic out_valid,
	input  logic out_ready,
	output rsqc_pkg::front_t out_d
);

	logic v_s1;
	rsqc_pkg::front_t nxt;
	logic signed [rsqc_pkg::CW:0] ext_c [2];
	logic signed [rsqc_pkg::CW:0] span_c [2];
	rsqc_pkg::ext_t abs_c [2];
	logic pos_c [2];
	logic lt [2];
	logic gt [2];
	rsqc_pkg::mag_t mv_lo [2];
	rsqc_pkg::mag_t mv_hi [2];

	assign in_ready = !v_s1 || out_ready;
	assign out_valid = v_s1;

	always_comb begin
		nxt = '0;
		for (int a = 0; a < 2; a++) begin
			ext_c[a] = (rsqc_pkg::CW+1)'($signed(src_i[a+2]))
				- (rsqc_pkg::CW+1)'($signed(src_i[a]));
			span_c[a] = (rsqc_pkg::CW+1)'($signed(dst_i[a+2]))
				- (rsqc_pkg::CW+1)'($signed(dst_i[a]));
			abs_c[a] = ext_c[a][rsqc_pkg::CW] ? rsqc_pkg::ext_t'(-ext_c[a])
				: rsqc_pkg::ext_t'(ext_c[a]);
			pos_c[a] = !span_c[a][rsqc_pkg::CW] && (span_c[a] != '0);
			lt[a] = $signed(dst_i[a]) < $signed(cfg.bound[a]);
			gt[a] = $signed(dst_i[a+2]) > $signed(cfg.bound[a+2]);
			mv_lo[a] = lt[a] ? rsqc_pkg::mag_t'(cfg.bound[a] - dst_i[a]) : '0;
			mv_hi[a] = gt[a] ? rsqc_pkg::mag_t'(dst_i[a+2] - cfg.bound[a+2]) : '0;

			nxt.dst[a] = dst_i[a];
			nxt.dst[a+2] = dst_i[a+2];
			nxt.lane[a].dv = rsqc_pkg::mag_t'(1);
			nxt.lane[a].src = src_i[a];
			nxt.lane[a+2].dv = rsqc_pkg::mag_t'(1);
			nxt.lane[a+2].src = src_i[a+2];

			if (cfg.en) begin
				unique case (action)
					rsqc_pkg::ACT_BAR: begin
						if (lt[a])
							nxt.dst[a] = cfg.bound[a];
						else if ($signed(dst_i[a]) > $signed(cfg.bound[a+2]))
							nxt.dst[a] = cfg.bound[a+2];
						if (gt[a])
							nxt.dst[a+2] = cfg.bound[a+2];
						else if ($signed(dst_i[a+2]) < $signed(cfg.bound[a]))
							nxt.dst[a+2] = cfg.bound[a];
					end
					rsqc_pkg::ACT_QUAD: begin
						if (lt[a]) nxt.dst[a] = cfg.bound[a];
						if (gt[a]) nxt.dst[a+2] = cfg.bound[a+2];
						nxt.lane[a].neg = ext_c[a][rsqc_pkg::CW];
						nxt.lane[a].mag = pos_c[a] ? abs_c[a] : '0;
						nxt.lane[a].mv = mv_lo[a];
						nxt.lane[a+2].neg = !ext_c[a][rsqc_pkg::CW];
						nxt.lane[a+2].mag = pos_c[a] ? abs_c[a] : '0;
						nxt.lane[a+2].mv = mv_hi[a];
						if (pos_c[a]) begin
							nxt.lane[a].dv = rsqc_pkg::mag_t'(span_c[a]);
							nxt.lane[a+2].dv = rsqc_pkg::mag_t'(span_c[a]);
						end
					end
					rsqc_pkg::ACT_SPRITE: begin
						if (lt[a]) nxt.dst[a] = cfg.bound[a];
						if (gt[a]) nxt.dst[a+2] = cfg.bound[a+2];
						nxt.lane[a].mag = rsqc_pkg::ext_t'(1);
						nxt.lane[a].mv = flip[a] ? mv_hi[a] : mv_lo[a];
						nxt.lane[a+2].neg = 1'b1;
						nxt.lane[a+2].mag = rsqc_pkg::ext_t'(1);
						nxt.lane[a+2].mv = flip[a] ? mv_lo[a] : mv_hi[a];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_d <= nxt;
		end
	end

endmodule

// File: hw/rtl/rsqc_mul.sv
module rsqc_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rsqc_pkg::front_t in_d,
	output logic out_valid,
	input  logic out_ready,
	output rsqc_pkg::pipe_t out_d
);

	logic v_s2;
	logic v_s3;
	logic rdy_s3;
	rsqc_pkg::mul_t m_s2;
	rsqc_pkg::mul_t m_nxt;
	rsqc_pkg::pipe_t p_nxt;

	assign rdy_s3 = !v_s3 || out_ready;
	assign in_ready = !v_s2 || rdy_s3;
	assign out_valid = v_s3;

	always_comb begin
		m_nxt.dst = in_d.dst;
		for (int i = 0; i < 4; i++) begin
			m_nxt.lane[i].neg = in_d.lane[i].neg;
			m_nxt.lane[i].prod = rsqc_pkg::PW'(in_d.lane[i].mag)
				* rsqc_pkg::PW'(in_d.lane[i].mv);
			m_nxt.lane[i].dv = in_d.lane[i].dv;
			m_nxt.lane[i].src = in_d.lane[i].src;
		end
	end

	// quotient too wide for the low part is flagged for capping
	always_comb begin
		p_nxt.dst = m_s2.dst;
		for (int i = 0; i < 4; i++) begin
			p_nxt.lane[i].neg = m_s2.lane[i].neg;
			p_nxt.lane[i].ovf = m_s2.lane[i].prod[rsqc_pkg::PW-1:rsqc_pkg::LW]
				>= rsqc_pkg::HW'(m_s2.lane[i].dv);
			p_nxt.lane[i].rem = rsqc_pkg::CW'(m_s2.lane[i].prod[rsqc_pkg::PW-1:rsqc_pkg::LW]);
			p_nxt.lane[i].lo = m_s2.lane[i].prod[rsqc_pkg::LW-1:0];
			p_nxt.lane[i].dv = m_s2.lane[i].dv;
			p_nxt.lane[i].src = m_s2.lane[i].src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) m_s2 <= m_nxt;
		if (rdy_s3 && v_s2) out_d <= p_nxt;
	end

endmodule

// File: hw/rtl/rsqc_div_stage.sv
module rsqc_div_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rsqc_pkg::pipe_t in_d,
	output logic out_valid,
	input  logic out_ready,
	output rsqc_pkg::pipe_t out_d
);

	logic v_q;
	rsqc_pkg::pipe_t nxt;

	// one restoring step: quotient bits shift in as dividend bits shift out
	function automatic rsqc_pkg::div_lane_t div_step(input rsqc_pkg::div_lane_t x);
		rsqc_pkg::div_lane_t y;
		logic [rsqc_pkg::CW:0] r2;
		y = x;
		r2 = {x.rem, x.lo[rsqc_pkg::LW-1]};
		y.lo = {x.lo[rsqc_pkg::LW-2:0], 1'b0};
		if (r2 >= {1'b0, x.dv}) begin
			y.rem = rsqc_pkg::CW'(r2 - {1'b0, x.dv});
			y.lo[0] = 1'b1;
		end else begin
			y.rem = r2[rsqc_pkg::CW-1:0];
		end
		return y;
	endfunction

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		nxt = in_d;
		for (int i = 0; i < 4; i++) begin
			for (int s = 0; s < rsqc_pkg::SPS; s++) begin
				nxt.lane[i] = div_step(nxt.lane[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) out_d <= nxt;
	end

endmodule

// File: hw/rtl/rsqc_back.sv
module rsqc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rsqc_pkg::pipe_t in_d,
	output logic out_valid,
	input  logic out_ready,
	output rsqc_pkg::result_t out_d
);

	logic v_q;
	rsqc_pkg::result_t nxt;
	logic [rsqc_pkg::LW:0] mag [4];
	logic signed [rsqc_pkg::SW-1:0] mx [4];
	logic signed [rsqc_pkg::SW-1:0] sum [4];

	assign in_ready = !v_q || out_ready;
	assign out_valid = v_q;

	always_comb begin
		nxt.dst = in_d.dst;
		for (int i = 0; i < 4; i++) begin
			mag[i] = in_d.lane[i].ovf ? {1'b1, rsqc_pkg::LW'(0)} : {1'b0, in_d.lane[i].lo};
			mx[i] = signed'(rsqc_pkg::SW'(mag[i]));
			sum[i] = rsqc_pkg::SW'($signed(in_d.lane[i].src)) + (in_d.lane[i].neg ? -mx[i] : mx[i]);
			if (sum[i] > rsqc_pkg::SW'(rsqc_pkg::CMAX))
				nxt.src[i] = rsqc_pkg::CMAX;
			else if (sum[i] < rsqc_pkg::SW'(rsqc_pkg::CMIN))
				nxt.src[i] = rsqc_pkg::CMIN;
			else
				nxt.src[i] = rsqc_pkg::CW'(sum[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) out_d <= nxt;
	end

endmodule

// File: hw/rtl/rect_sprite_quad_clipper_core.sv
// Scissor clipper for blitter rectangles: each request carries a destination and a source
// rectangle in signed Q15.8 and returns the destination clipped to the scissor registers plus
// the source adjusted to match (bar clamp, scaled quad, or sprite shift with flips), with
// source edges saturated. Fully pipelined: one request per cycle unless the result side stalls.
// Every request passes through the stages of the scaled-quad path: one stage of edge clamping,
// one multiply stage, one stage of divider setup, twelve restoring-divider stages retiring
// two quotient bits each, and the output register. Stalls on the result side back up through
// the stages, filling bubbles first. Scissor registers are written through the cfg port and
// should change only while the pipeline is empty.
module rect_sprite_quad_clipper_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rsqc_pkg::IDX_W-1:0] cfg_index,
	input  logic [rsqc_pkg::CW-1:0] cfg_wdata,
	rsqc_req_if.sink req,
	rsqc_rsp_if.source rsp
);

	rsqc_pkg::cfg_t cfg_q;
	rsqc_pkg::coord_t [3:0] dst_i;
	rsqc_pkg::coord_t [3:0] src_i;
	logic f_valid;
	logic f_ready;
	rsqc_pkg::front_t f_d;
	logic d_valid [rsqc_pkg::DIV_STAGES+1];
	logic d_ready [rsqc_pkg::DIV_STAGES+1];
	rsqc_pkg::pipe_t d_d [rsqc_pkg::DIV_STAGES+1];
	rsqc_pkg::result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsqc_pkg::REG_ENABLE: cfg_q.en <= cfg_wdata[0];
				rsqc_pkg::REG_LEFT:   cfg_q.bound[0] <= rsqc_pkg::coord_t'(cfg_wdata);
				rsqc_pkg::REG_TOP:    cfg_q.bound[1] <= rsqc_pkg::coord_t'(cfg_wdata);
				rsqc_pkg::REG_RIGHT:  cfg_q.bound[2] <= rsqc_pkg::coord_t'(cfg_wdata);
				rsqc_pkg::REG_BOTTOM: cfg_q.bound[3] <= rsqc_pkg::coord_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	assign dst_i = {req.dst_bottom, req.dst_right, req.dst_top, req.dst_left};
	assign src_i = {req.src_bottom, req.src_right, req.src_top, req.src_left};

	rsqc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.action(req.action),
		.flip({req.flip_y, req.flip_x}),
		.dst_i(dst_i),
		.src_i(src_i),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_d(f_d)
	);

	rsqc_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(f_valid),
		.in_ready(f_ready),
		.in_d(f_d),
		.out_valid(d_valid[0]),
		.out_ready(d_ready[0]),
		.out_d(d_d[0])
	);

	for (genvar g = 0; g < rsqc_pkg::DIV_STAGES; g++) begin : g_div
		rsqc_div_stage u_div (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(d_valid[g]),
			.in_ready(d_ready[g]),
			.in_d(d_d[g]),
			.out_valid(d_valid[g+1]),
			.out_ready(d_ready[g+1]),
			.out_d(d_d[g+1])
		);
	end

	rsqc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(d_valid[rsqc_pkg::DIV_STAGES]),
		.in_ready(d_ready[rsqc_pkg::DIV_STAGES]),
		.in_d(d_d[rsqc_pkg::DIV_STAGES]),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.out_d(res)
	);

	assign rsp.out_dst_left   = res.dst[0];
	assign rsp.out_dst_top    = res.dst[1];
	assign rsp.out_dst_right  = res.dst[2];
	assign rsp.out_dst_bottom = res.dst[3];
	assign rsp.out_src_left   = res.src[0];
	assign rsp.out_src_top    = res.src[1];
	assign rsp.out_src_right  = res.src[2];
	assign rsp.out_src_bottom = res.src[3];

endmodule

// File: hw/rtl/rsqc_checker.sv
`include "rect_sprite_quad_clipper_core_assert.svh"

module rsqc_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsqc_pkg::coord_t rsp_dst_left
);

	logic [rsqc_pkg::CNT_W-1:0] cnt_q;

	// requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + rsqc_pkg::CNT_W'(req_valid && req_ready)
				- rsqc_pkg::CNT_W'(rsp_valid && rsp_ready);
		end
	end

	`RSQC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dst_left), "result dropped or changed while stalled")
	`RSQC_ASSERT(a_no_extra, rsp_valid |-> cnt_q != '0, "result without a pending request")
	`RSQC_ASSERT(a_empty_ready, cnt_q == '0 |-> req_ready, "empty pipeline refuses a request")
	`RSQC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "result valid during reset")

endmodule

bind rect_sprite_quad_clipper_core rsqc_checker u_rsqc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_dst_left(rsp.out_dst_left)
);
